// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/mp2d_pkg.sv -----
package mp2d_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_COLUMNS = 2'd0,
    REG_FRAME_ROWS    = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_REGION_SIZE   = 2'd3
  } cfg_reg_t;

  // Register widths
  localparam int CFG_DATA_W = 11;
  localparam int COLS_W     = 9;
  localparam int ROWS_W     = 11;
  localparam int CHANS_W    = 4;
  localparam int REGION_W   = 4;

  // Fixed limits
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_CNT_W  = 10;
  localparam int MAX_REGION = 8;
  localparam int PHASE_W    = 3;

  // Reset values
  localparam logic [COLS_W-1:0]   COLS_RST   = 9'd8;
  localparam logic [ROWS_W-1:0]   ROWS_RST   = 11'd8;
  localparam logic [CHANS_W-1:0]  CHANS_RST  = 4'd1;
  localparam logic [REGION_W-1:0] REGION_RST = 4'd2;

endpackage

// ----- src/max_pooling_2d.sv -----
// Streaming 2-D max pooling with a line store of partial maxima.
// A pooled word passes through the update stage and the output queue before it shows on out_.
// Throughput: one sample per cycle while in_ready is high, one read-modify-write of the store per word; a
//   same-entry write and read in adjacent cycles is covered by forwarding.
// Input stalls only while the queue and the update stage together hold three or more pooled words.
// Reset (rst_n low, synchronous): registers to 8, 8, 1, 2, counters and queue clear; store kept.
`include "assert_macros.svh"

module max_pooling_2d #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // sample stream
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  // pooled stream
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_pooled_value,
  output logic                               out_frame_done
);
  import mp2d_pkg::*;

  localparam int CV_W   = $clog2(MAX_COLUMNS + 1);
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH  = MAX_COLUMNS * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FP_W   = 2;

  // Configuration registers
  logic [COLS_W-1:0]   cols_cfg_r;
  logic [ROWS_W-1:0]   rows_cfg_r;
  logic [CHANS_W-1:0]  chans_cfg_r;
  logic [REGION_W-1:0] region_cfg_r;

  // Position counters
  logic [CH_W-1:0]      chan_cnt_r;
  logic [CV_W-1:0]      col_cnt_r;
  logic [ROW_CNT_W-1:0] row_cnt_r;
  logic [PHASE_W-1:0]   col_ph_r;
  logic [PHASE_W-1:0]   row_ph_r;
  logic [CV_W-1:0]      bcol_r;

  // Update stage
  logic                          s1_valid_r;
  logic [ADDR_W-1:0]             s1_addr_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_seed_r;
  logic                          s1_emit_r;
  logic                          s1_done_r;
  logic                          s1_fwd_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] last_wr_r;
  logic signed [SAMPLE_BITS-1:0] s1_prev;
  logic signed [SAMPLE_BITS-1:0] s1_max;

  // Line store
  logic signed [SAMPLE_BITS-1:0] store [DEPTH];

  // Output queue
  logic signed [SAMPLE_BITS-1:0] fifo_val [FIFO_DEPTH];
  logic                          fifo_done [FIFO_DEPTH];
  logic [FP_W-1:0]               wp_r;
  logic [FP_W-1:0]               rp_r;
  logic [FP_W:0]                 cnt_r;

  // Clamped configuration values
  logic [CV_W-1:0]     cols_v;
  logic [ROWS_W-1:0]   rows_v;
  logic [CH_W-1:0]     chans_v;
  logic [REGION_W-1:0] region_v;

  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_v = CV_W'(1);
    end else if (32'(cols_cfg_r) > MAX_COLUMNS) begin
      cols_v = CV_W'(MAX_COLUMNS);
    end else begin
      cols_v = CV_W'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_v = ROWS_W'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_v = ROWS_W'(MAX_ROWS);
    end else begin
      rows_v = rows_cfg_r;
    end
    if (chans_cfg_r == '0) begin
      chans_v = CH_W'(1);
    end else if (32'(chans_cfg_r) > MAX_CHANNELS) begin
      chans_v = CH_W'(MAX_CHANNELS);
    end else begin
      chans_v = CH_W'(chans_cfg_r);
    end
    if (region_cfg_r == '0) begin
      region_v = REGION_W'(1);
    end else if (32'(region_cfg_r) > MAX_REGION) begin
      region_v = REGION_W'(MAX_REGION);
    end else begin
      region_v = region_cfg_r;
    end
  end

  // Window position of the incoming word
  logic              in_fire;
  logic              last_chan, last_col, last_row, col_wrap, row_wrap;
  logic              col_end, row_end;
  logic [ADDR_W-1:0] rd_addr;

  assign in_fire   = in_valid && in_ready;
  assign last_chan = (chan_cnt_r == chans_v - CH_W'(1));
  assign last_col  = (col_cnt_r == cols_v - CV_W'(1));
  assign last_row  = (row_cnt_r == ROW_CNT_W'(rows_v - ROWS_W'(1)));
  assign col_wrap  = (col_ph_r == PHASE_W'(region_v - REGION_W'(1)));
  assign row_wrap  = (row_ph_r == PHASE_W'(region_v - REGION_W'(1)));
  assign col_end   = last_col || col_wrap;
  assign row_end   = last_row || row_wrap;
  assign rd_addr   = ADDR_W'(32'(bcol_r) * MAX_CHANNELS + 32'(chan_cnt_r));

  // Admit a word only if the queue can take every result in flight
  assign in_ready = (cnt_r + (FP_W + 1)'(s1_valid_r && s1_emit_r))
                    <= (FP_W + 1)'(FIFO_DEPTH - 2);

  // Config writes and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r   <= COLS_RST;
      rows_cfg_r   <= ROWS_RST;
      chans_cfg_r  <= CHANS_RST;
      region_cfg_r <= REGION_RST;
      chan_cnt_r   <= '0;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      col_ph_r     <= '0;
      row_ph_r     <= '0;
      bcol_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_COLUMNS: cols_cfg_r   <= cfg_wdata[COLS_W-1:0];
        REG_FRAME_ROWS:    rows_cfg_r   <= cfg_wdata[ROWS_W-1:0];
        REG_CHANNEL_COUNT: chans_cfg_r  <= cfg_wdata[CHANS_W-1:0];
        REG_REGION_SIZE:   region_cfg_r <= cfg_wdata[REGION_W-1:0];
        default: ;
      endcase
      chan_cnt_r <= '0;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      col_ph_r   <= '0;
      row_ph_r   <= '0;
      bcol_r     <= '0;
    end else if (in_fire) begin
      if (!last_chan) begin
        chan_cnt_r <= chan_cnt_r + CH_W'(1);
      end else begin
        chan_cnt_r <= '0;
        if (!last_col) begin
          col_cnt_r <= col_cnt_r + CV_W'(1);
          if (col_wrap) begin
            col_ph_r <= '0;
            bcol_r   <= bcol_r + CV_W'(1);
          end else begin
            col_ph_r <= col_ph_r + PHASE_W'(1);
          end
        end else begin
          col_cnt_r <= '0;
          col_ph_r  <= '0;
          bcol_r    <= '0;
          if (!last_row) begin
            row_cnt_r <= row_cnt_r + ROW_CNT_W'(1);
            row_ph_r  <= row_wrap ? '0 : row_ph_r + PHASE_W'(1);
          end else begin
            row_cnt_r <= '0;
            row_ph_r  <= '0;
          end
        end
      end
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  // Update stage payload; forward when the previous word writes the same entry now
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r   <= rd_addr;
      s1_sample_r <= in_sample;
      s1_seed_r   <= (row_ph_r == '0) && (col_ph_r == '0);
      s1_emit_r   <= col_end && row_end;
      s1_done_r   <= last_chan && last_col && last_row;
      s1_fwd_r    <= s1_valid_r && (s1_addr_r == rd_addr);
    end
    if (s1_valid_r) begin
      last_wr_r <= s1_max;
    end
  end

  // Read-modify-write of the line store
  assign s1_prev = s1_fwd_r ? last_wr_r : rd_data_r;
  assign s1_max  = (s1_seed_r || (s1_sample_r > s1_prev)) ? s1_sample_r : s1_prev;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= store[rd_addr];
    end
    if (s1_valid_r) begin
      store[s1_addr_r] <= s1_max;
    end
  end

  // Output queue
  logic push, pop;
  assign push = s1_valid_r && s1_emit_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FP_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FP_W'(1);
      end
      cnt_r <= cnt_r + (FP_W + 1)'(push) - (FP_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_val[wp_r]  <= s1_max;
      fifo_done[wp_r] <= s1_done_r;
    end
  end

  assign out_valid        = (cnt_r != '0);
  assign out_pooled_value = fifo_val[rp_r];
  assign out_frame_done   = fifo_done[rp_r];

  // Checks
  `ASSERT_IMPLY(a_no_overflow, push && !pop, cnt_r < (FP_W + 1)'(FIFO_DEPTH), "output queue overflow")
  `ASSERT_ALWAYS(a_col_phase, 32'(col_ph_r) < 32'(region_v), "column phase beyond window")
  `ASSERT_ALWAYS(a_chan_bound, chan_cnt_r < chans_v, "channel counter beyond channel count")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mp2d_pkg::*;

  localparam int MAX_COLUMNS    = 256;
  localparam int MAX_CHANNELS   = 8;
  localparam int SAMPLE_W       = 16;
  localparam int STORE_DEPTH    = MAX_COLUMNS * MAX_CHANNELS;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 80;
  localparam int IDLE_PCT       = 38;

  typedef struct {
    logic signed [SAMPLE_W-1:0] pooled_value;
    logic                       frame_done;
  } pooled_word_t;

  // DUT connections; the DUT inputs are driven from time zero
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_pooled_value;
  logic                       out_frame_done;

  // traffic shaping
  bit   sender_gaps_on = 1'b1;
  bit   receiver_stalls_on = 1'b1;
  bit   holdoff_active = 1'b0;
  event holdoff_go;

  // pooling predictor: registers, counters and line store
  logic [COLS_W-1:0]          cols_cfg = COLS_RST;
  logic [ROWS_W-1:0]          rows_cfg = ROWS_RST;
  logic [CHANS_W-1:0]         chans_cfg = CHANS_RST;
  logic [REGION_W-1:0]        region_cfg = REGION_RST;
  logic [2:0]                 chan_idx = '0;
  logic [7:0]                 col_cnt = '0;
  logic [ROW_CNT_W-1:0]       row_cnt = '0;
  logic [PHASE_W-1:0]         col_ph = '0;
  logic [PHASE_W-1:0]         row_ph = '0;
  logic [7:0]                 blk_col = '0;
  logic signed [SAMPLE_W-1:0] max_store [0:STORE_DEPTH-1];

  pooled_word_t pooled_expect[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  max_pooling_2d u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_frame_done   (out_frame_done)
  );

  always #5 clk = ~clk;

  // zero reads as 1, anything past the top reads as the top
  function automatic int unsigned used_value(input int unsigned raw, input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return 16'($urandom_range(0, 31) - 16);  // near zero, lots of ties
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic restart_frame();
    chan_idx = '0;
    col_cnt  = '0;
    row_cnt  = '0;
    col_ph   = '0;
    row_ph   = '0;
    blk_col  = '0;
  endtask

  // any register write restarts the frame; the store is kept
  task automatic apply_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (cfg_reg_t'(idx))
      REG_FRAME_COLUMNS: cols_cfg   = value[COLS_W-1:0];
      REG_FRAME_ROWS:    rows_cfg   = value[ROWS_W-1:0];
      REG_CHANNEL_COUNT: chans_cfg  = value[CHANS_W-1:0];
      REG_REGION_SIZE:   region_cfg = value[REGION_W-1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  // one sample through the window logic; queues a pooled word when a window closes
  task automatic pool_sample(input logic signed [SAMPLE_W-1:0] pix);
    int unsigned ncols, nrows, nchans, nreg, slot;
    logic signed [SAMPLE_W-1:0] run_max;
    bit last_chan, last_col, last_row, col_end, row_end;
    ncols  = used_value(cols_cfg, MAX_COLUMNS);
    nrows  = used_value(rows_cfg, MAX_ROWS);
    nchans = used_value(chans_cfg, MAX_CHANNELS);
    nreg   = used_value(region_cfg, MAX_REGION);
    slot   = blk_col * MAX_CHANNELS + chan_idx;

    // window corner seeds the running max
    if (row_ph == 0 && col_ph == 0) begin
      run_max = pix;
    end else begin
      run_max = max_store[slot];
      if (pix > run_max) run_max = pix;
    end
    max_store[slot] = run_max;

    last_chan = (chan_idx + 1 >= nchans);
    last_col  = (col_cnt + 1 >= ncols);
    last_row  = (row_cnt + 1 >= nrows);
    col_end   = last_col || (col_ph + 1 >= nreg);
    row_end   = last_row || (row_ph + 1 >= nreg);
    if (col_end && row_end)
      pooled_expect.push_back('{run_max, last_chan && last_col && last_row});

    // advance channel, column, row
    if (!last_chan) begin
      chan_idx++;
    end else begin
      chan_idx = '0;
      if (!last_col) begin
        col_cnt++;
        if (col_ph + 1 >= nreg) begin
          col_ph = '0;
          blk_col++;
        end else begin
          col_ph++;
        end
      end else begin
        col_cnt = '0;
        col_ph  = '0;
        blk_col = '0;
        if (!last_row) begin
          row_cnt++;
          if (row_ph + 1 >= nreg) row_ph = '0;
          else row_ph++;
        end else begin
          row_cnt = '0;
          row_ph  = '0;
        end
      end
    end
  endtask

  task automatic check_pooled();
    pooled_word_t want;
    if (pooled_expect.size() == 0) begin
      $error("pooled word %0d with no window closed", out_pooled_value);
      mismatch_count++;
    end else begin
      want = pooled_expect.pop_front();
      if (out_pooled_value !== want.pooled_value) begin
        $error("pooled_value: expected %0d, got %0d", want.pooled_value, out_pooled_value);
        mismatch_count++;
      end
      if (out_frame_done !== want.frame_done) begin
        $error("frame_done: expected %0b, got %0b", want.frame_done, out_frame_done);
        mismatch_count++;
      end
    end
  endtask

  // monitor: register writes, accepted samples and pooled words, in that order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);
      if (in_valid && in_ready) pool_sample(in_sample);
      if (out_valid && out_ready) check_pooled();
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles, %0d pooled words outstanding",
             quiet_cycles, pooled_expect.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver long hold-off, counted here
  always begin
    @(holdoff_go);
    holdoff_active <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    holdoff_active <= 1'b0;
  end

  // receiver ready
  always @(negedge clk) begin
    if (holdoff_active) out_ready <= 1'b0;
    else if (receiver_stalls_on) out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    else out_ready <= 1'b1;
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    @(negedge clk);
    while (sender_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(rand_value());
  endtask

  // stop sending, let every pooled word out, then let the pipe settle
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pooled_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] ncols, input logic [CFG_DATA_W-1:0] nrows,
                           input logic [CFG_DATA_W-1:0] nchans,
                           input logic [CFG_DATA_W-1:0] nreg);
    drain_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_COLUMNS;
    cfg_wdata <= ncols;
    @(negedge clk);
    cfg_index <= REG_FRAME_ROWS;
    cfg_wdata <= nrows;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= nchans;
    @(negedge clk);
    cfg_index <= REG_REGION_SIZE;
    cfg_wdata <= nreg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reset values: 8x8 frame, one channel, 2x2 windows; first block row
  task automatic test_reset_values();
    logic signed [SAMPLE_W-1:0] rows_in [0:15];
    rows_in = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, -16'sd2, 16'sd100, -16'sd200,
                16'sh8000, 16'sh8000, -16'sd5, 16'sd1, -16'sd3, -16'sd4, -16'sd300, 16'sd256};
    foreach (rows_in[i]) send_sample(rows_in[i]);
  endtask

  // 3x3 frame with 2x2 windows: partial windows on the right and bottom edges
  task automatic test_partial_windows();
    configure(3, 3, 1, 2);
    send_random(9);
  endtask

  // zero and above-range register values, masked upper bits included
  task automatic test_register_limits();
    configure(0, 0, 0, 0);
    send_random(6);
    configure(11'h7FF, 1, 1, 11'h7FF);
    send_random(48);
    configure(256, 1, 1, 1);
    send_random(16);
    configure(1, 11'h7FF, 1, 8);
    send_random(24);
    configure(2, 2, 11'h7FF, 2);
    send_random(32);
    configure(8, 8, 1, 8);
    send_random(64);
  endtask

  // a register write mid-frame starts a fresh frame
  task automatic test_frame_restart();
    configure(4, 4, 2, 2);
    send_random(11);
    configure(4, 4, 2, 2);
    send_random(32);
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    configure(6, 4, 2, 2);
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    send_random(48);
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // every sample closes a window while the receiver holds off: input must stall
  task automatic test_backpressure();
    configure(4, 8, 1, 1);
    -> holdoff_go;
    send_random(32);
  endtask

  // random small frames; some abandoned part way, some running into the next frame
  task automatic test_random_frames();
    int unsigned sent, ncols, nrows, nchans, nreg, frame_len, burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      nchans = $urandom_range(1, 4);
      ncols  = $urandom_range(1, 12);
      nrows  = $urandom_range(1, 8);
      nreg   = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) begin
        nchans = 8;
        ncols  = $urandom_range(1, 4);
        nrows  = $urandom_range(1, 4);
      end
      if ($urandom_range(0, 7) == 0) nreg = 8;
      configure(ncols, nrows, nchans, nreg);
      frame_len = ncols * nrows * nchans;
      case ($urandom_range(0, 7))
        0, 1:    burst = $urandom_range(1, frame_len);
        2:       burst = frame_len + $urandom_range(1, frame_len);
        default: burst = frame_len;
      endcase
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      send_random(burst);
      sent += burst;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_partial_windows();
    test_register_limits();
    test_frame_restart();
    test_back_to_back();
    test_backpressure();
    test_random_frames();
    drain_block();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/mp2d_pkg.sv
src/max_pooling_2d.sv
tb/tb.sv
